// ----- rtl/dcct_pkg.sv -----
// Shared constants and month length table for the day count to calendar time converter.
package dcct_pkg;

    localparam int DEF_TICKS_PER_SEC  = 50;
    localparam int DEF_DAY_COUNT_BITS = 16;

    localparam int FIRST_YEAR      = 1978;
    localparam int YEAR_DAYS       = 365;
    localparam int LEAP_YEAR_DAYS  = 366;
    localparam int MINUTES_PER_HR  = 60;
    localparam int SECONDS_PER_MIN = 60;
    localparam int LAST_MINUTE     = 1439;
    localparam int LAST_MONTH_IDX  = 11;

    localparam int FIRST_Y4   = FIRST_YEAR % 4;
    localparam int FIRST_Y100 = FIRST_YEAR % 100;
    localparam int FIRST_Y400 = FIRST_YEAR % 400;

    localparam int MINUTE_W = 11;
    localparam int TICK_W   = 12;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;

    typedef logic [MONTH_W-1:0] t_month_idx;
    typedef logic [DAY_W-1:0]   t_month_len;

    function automatic t_month_len month_len(input logic leap, input t_month_idx idx);
        t_month_len len;
        unique case (idx)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
            4'd1:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/day_count_to_calendar_time_core.sv -----
// Day count to calendar time converter: sequenced shared subtractor, one request at a time.
// It walks whole years, then whole months, whole hours and whole seconds, by repeated subtraction.
// One shared compare-subtract unit does every step; busy until the strobe, so a new request waits for the last result.
// The result is shown for one cycle with o_valid; the receiver cannot stall.
// Reset (synchronous, active low) returns the sequencer to idle and clears o_valid.
module day_count_to_calendar_time_core #(
    parameter int TICKS_PER_SEC  = dcct_pkg::DEF_TICKS_PER_SEC,
    parameter int DAY_COUNT_BITS = dcct_pkg::DEF_DAY_COUNT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [DAY_COUNT_BITS-1:0]     i_day_count,
    input  logic [dcct_pkg::MINUTE_W-1:0] i_minute_of_day,
    input  logic [dcct_pkg::TICK_W-1:0]   i_tick_in_minute,
    output logic                          o_valid,
    output logic [dcct_pkg::DAY_W-1:0]    o_day_of_month,
    output logic [dcct_pkg::MONTH_W-1:0]  o_month_number,
    output logic [dcct_pkg::YEAR_W-1:0]   o_year_number,
    output logic [dcct_pkg::HOUR_W-1:0]   o_hour_of_day,
    output logic [dcct_pkg::MIN_W-1:0]    o_minute_of_hour,
    output logic [dcct_pkg::SEC_W-1:0]    o_second_of_minute
);
    import dcct_pkg::*;

    localparam int REM_BITS  = (DAY_COUNT_BITS > TICK_W) ? DAY_COUNT_BITS : TICK_W;
    localparam int YEAR_RAW  = $clog2(FIRST_YEAR + (1 << DAY_COUNT_BITS) / YEAR_DAYS + 2);
    localparam int YEAR_BITS = (YEAR_RAW > YEAR_W) ? YEAR_RAW : YEAR_W;
    localparam logic [15:0] TICK_MAX = 16'(SECONDS_PER_MIN * TICKS_PER_SEC - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_YEAR  = 3'd1;
    localparam logic [2:0] S_MONTH = 3'd2;
    localparam logic [2:0] S_HOUR  = 3'd3;
    localparam logic [2:0] S_SEC   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic                r_valid, n_valid;
    logic [REM_BITS-1:0] r_rem, n_rem;
    logic [MINUTE_W-1:0] r_mins, n_mins;
    logic [TICK_W-1:0]   r_ticks, n_ticks;
    logic [YEAR_BITS-1:0] r_year, n_year;
    logic [1:0]          r_y4, n_y4;
    logic [6:0]          r_y100, n_y100;
    logic [8:0]          r_y400, n_y400;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [HOUR_W-1:0]   r_hour, n_hour;
    logic [SEC_W-1:0]    r_sec, n_sec;
    logic [DAY_W-1:0]    r_out_day, n_out_day;
    logic [MIN_W-1:0]    r_out_min, n_out_min;

    logic                w_leap;
    logic [REM_BITS-1:0] w_op;
    logic [REM_BITS:0]   w_diff;
    logic                w_ge;
    logic [MINUTE_W-1:0] w_mins_clamp;
    logic [TICK_W-1:0]   w_ticks_clamp;

    assign w_leap = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);

    always_comb begin
        unique case (r_state)
            S_YEAR:  w_op = w_leap ? REM_BITS'(LEAP_YEAR_DAYS) : REM_BITS'(YEAR_DAYS);
            S_MONTH: w_op = REM_BITS'(month_len(w_leap, r_month));
            S_HOUR:  w_op = REM_BITS'(MINUTES_PER_HR);
            S_SEC:   w_op = REM_BITS'(TICKS_PER_SEC);
            default: w_op = '0;
        endcase
    end

    assign w_diff = {1'b0, r_rem} - {1'b0, w_op};
    assign w_ge   = ~w_diff[REM_BITS];

    assign w_mins_clamp  = (i_minute_of_day > MINUTE_W'(LAST_MINUTE)) ?
                           MINUTE_W'(LAST_MINUTE) : i_minute_of_day;
    assign w_ticks_clamp = (16'(i_tick_in_minute) > TICK_MAX) ?
                           TICK_MAX[TICK_W-1:0] : i_tick_in_minute;

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_rem     = r_rem;
        n_mins    = r_mins;
        n_ticks   = r_ticks;
        n_year    = r_year;
        n_y4      = r_y4;
        n_y100    = r_y100;
        n_y400    = r_y400;
        n_month   = r_month;
        n_hour    = r_hour;
        n_sec     = r_sec;
        n_out_day = r_out_day;
        n_out_min = r_out_min;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_YEAR;
                    n_rem   = REM_BITS'(i_day_count);
                    n_mins  = w_mins_clamp;
                    n_ticks = w_ticks_clamp;
                    n_year  = YEAR_BITS'(FIRST_YEAR);
                    n_y4    = 2'(FIRST_Y4);
                    n_y100  = 7'(FIRST_Y100);
                    n_y400  = 9'(FIRST_Y400);
                end
            end
            S_YEAR: begin
                if (w_ge) begin
                    n_rem  = w_diff[REM_BITS-1:0];
                    n_year = r_year + 1'b1;
                    n_y4   = r_y4 + 1'b1;
                    n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 1'b1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 1'b1;
                end else begin
                    n_state = S_MONTH;
                    n_month = '0;
                end
            end
            S_MONTH: begin
                if (w_ge && (r_month != MONTH_W'(LAST_MONTH_IDX))) begin
                    n_rem   = w_diff[REM_BITS-1:0];
                    n_month = r_month + 1'b1;
                end else begin
                    n_state   = S_HOUR;
                    n_out_day = r_rem[DAY_W-1:0] + 1'b1;
                    n_rem     = REM_BITS'(r_mins);
                    n_hour    = '0;
                end
            end
            S_HOUR: begin
                if (w_ge) begin
                    n_rem  = w_diff[REM_BITS-1:0];
                    n_hour = r_hour + 1'b1;
                end else begin
                    n_state   = S_SEC;
                    n_out_min = r_rem[MIN_W-1:0];
                    n_rem     = REM_BITS'(r_ticks);
                    n_sec     = '0;
                end
            end
            S_SEC: begin
                if (w_ge) begin
                    n_rem = w_diff[REM_BITS-1:0];
                    n_sec = r_sec + 1'b1;
                end else begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_mins    <= n_mins;
        r_ticks   <= n_ticks;
        r_year    <= n_year;
        r_y4      <= n_y4;
        r_y100    <= n_y100;
        r_y400    <= n_y400;
        r_month   <= n_month;
        r_hour    <= n_hour;
        r_sec     <= n_sec;
        r_out_day <= n_out_day;
        r_out_min <= n_out_min;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_day_of_month     = r_out_day;
    assign o_month_number     = r_month + 1'b1;
    assign o_year_number      = r_year[YEAR_W-1:0];
    assign o_hour_of_day      = r_hour;
    assign o_minute_of_hour   = r_out_min;
    assign o_second_of_minute = r_sec;

endmodule
